FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHECK_IMPL(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

`define CHECK_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`define CHECK_DELAY(label, ck, rs, ante, n, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> ##n (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/vtu_pkg.sv
package vtu_pkg;

  localparam int AXES       = 3;
  localparam int TIME_W     = 31;
  localparam int RED_W      = 18;
  localparam int CFG_W      = 31;
  localparam int IDX_W      = 1;
  localparam int LANE_FRONT = 6;
  localparam int DIV_EXTRA  = 3;

  localparam logic [TIME_W-1:0] TIME_RESET = 31'd66;
  localparam logic [RED_W-1:0]  RED_RESET  = 18'd65536;

  typedef enum logic {
    CMD_PREDICT = 1'b0,
    CMD_CORRECT = 1'b1
  } cmd_t;

  typedef enum logic [IDX_W-1:0] {
    REG_TIME_STEP = 1'b0,
    REG_FORCE_RED = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic            valid;
    cmd_t            cmd;
    logic [AXES-1:0] fixed;
    logic            mass_zero;
  } ctrl_t;

  function automatic int max2(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

FILE: rtl/core/vtu_div.sv
module vtu_div
  import vtu_pkg::*;
#(
  parameter int W    = 32,
  parameter int NH_W = 80
) (
  input  logic          clk,
  input  logic [NH_W-1:0] num,
  input  logic          half,
  input  logic          neg,
  input  logic [W-1:0]  divisor,
  output logic [W-1:0]  quot
);

  localparam int HI_W = NH_W - W;

  logic [W-1:0] rem   [0:W];
  logic [W-1:0] low   [0:W];
  logic [W-1:0] q     [0:W];
  logic [W-1:0] m     [0:W];
  logic         sgn   [0:W];
  logic         hf    [0:W];
  logic         ovf   [0:W];
  logic [W:0]   trial [1:W];
  logic         take  [1:W];

  logic [W:0]   qr;
  logic         ovf_r;
  logic         neg_r;
  logic [W:0]   lim;
  logic [W:0]   qmag;

  always_comb begin
    for (int k = 1; k <= W; k++) begin
      trial[k] = {rem[k-1], low[k-1][W-1]};
      take[k]  = trial[k] >= {1'b0, m[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    ovf[0] <= num[NH_W-1:W] >= HI_W'(divisor);
    rem[0] <= num[2*W-1:W];
    low[0] <= num[W-1:0];
    q[0]   <= '0;
    m[0]   <= divisor;
    sgn[0] <= neg;
    hf[0]  <= half;
    for (int k = 1; k <= W; k++) begin
      rem[k] <= take[k] ? W'(trial[k] - {1'b0, m[k-1]}) : trial[k][W-1:0];
      low[k] <= {low[k-1][W-2:0], 1'b0};
      q[k]   <= {q[k-1][W-2:0], take[k]};
      m[k]   <= m[k-1];
      sgn[k] <= sgn[k-1];
      hf[k]  <= hf[k-1];
      ovf[k] <= ovf[k-1];
    end
  end

  always_ff @(posedge clk) begin
    qr    <= {1'b0, q[W]} + (W+1)'({rem[W], hf[W]} >= {1'b0, m[W]});
    ovf_r <= ovf[W];
    neg_r <= sgn[W];
  end

  always_comb begin
    lim  = neg_r ? ((W+1)'(1) << (W-1)) : (((W+1)'(1) << (W-1)) - (W+1)'(1));
    qmag = (ovf_r || (qr > lim)) ? lim : qr;
  end

  always_ff @(posedge clk) begin
    quot <= neg_r ? (~qmag[W-1:0] + 1'b1) : qmag[W-1:0];
  end

endmodule

FILE: rtl/core/vtu_lane.sv
module vtu_lane
  import vtu_pkg::*;
#(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk,
  input  logic [W-1:0]        mass,
  input  logic [TIME_W-1:0]   time_step,
  input  logic [RED_W-1:0]    force_reduction,
  input  logic signed [W-1:0] velocity,
  input  logic signed [W-1:0] displacement,
  input  logic signed [W-1:0] force_val,
  output logic [W-1:0]        kick,
  output logic [W-1:0]        dstep,
  output logic [W-1:0]        fstep,
  output logic [W-1:0]        vel_out,
  output logic [W-1:0]        disp_out
);

  localparam int PROD_W   = 2 * W;
  localparam int RG_W     = W + RED_W;
  localparam int GT_W     = W + TIME_W;
  localparam int A_W      = PROD_W + F + 1;
  localparam int VMT_W    = PROD_W + TIME_W;
  localparam int RGT_W    = RG_W + TIME_W;
  localparam int GTT_W    = GT_W + TIME_W;
  localparam int NUM_W    = max2(max2(A_W, RGT_W), max2(VMT_W + 1, GTT_W)) + 1;
  localparam int NH_W     = NUM_W - F - 1;
  localparam int FR_W     = GT_W - F + 1;
  localparam int LANE_LAT = W + LANE_FRONT + DIV_EXTRA;
  localparam int FS_LAT   = LANE_LAT - 4;

  logic [W-1:0]        av1, ag1, m1;
  logic                sv1, sg1;

  logic [PROD_W-1:0]   p1_2;
  logic [RG_W-1:0]     p2_2;
  logic [GT_W-1:0]     p3_2;
  logic [GT_W-1:0]     pf_2;
  logic [W-1:0]        m2;
  logic                sv2, sg2;

  logic [W+TIME_W-1:0]     q1l, q1h, q2l, q3l;
  logic [RED_W+TIME_W-1:0] q2h;
  logic [2*TIME_W-1:0]     q3h;
  logic [PROD_W-1:0]   p1_3;
  logic [FR_W-1:0]     fr3;
  logic [W-1:0]        m3;
  logic                sv3, sg3;

  logic [VMT_W-1:0]    vmt4;
  logic [RGT_W-1:0]    rgt4;
  logic [GTT_W-1:0]    gtt4;
  logic [PROD_W-1:0]   p1_4;
  logic [W-1:0]        f4;
  logic [W-1:0]        m4;
  logic                sv4, sg4;
  logic [FR_W-1:0]     flim;
  logic [FR_W-1:0]     fmag;

  logic [NUM_W-1:0]    ka, kb, sa, sb;
  logic [NUM_W-1:0]    kval5, sval5;
  logic                ksub5, ssub5, sv5;
  logic [W-1:0]        m5;

  logic [NUM_W-1:0]    kmag, smag;
  logic                kflip, sflip;
  logic [NH_W-1:0]     knh6, snh6;
  logic                khalf6, shalf6, kneg6, sneg6;
  logic [W-1:0]        m6;

  logic [W-1:0]        vel_line  [0:LANE_LAT-1];
  logic [W-1:0]        disp_line [0:LANE_LAT-1];
  logic [W-1:0]        fs_line   [0:FS_LAT-1];

  always_ff @(posedge clk) begin
    av1 <= velocity[W-1] ? $unsigned(-velocity) : $unsigned(velocity);
    ag1 <= force_val[W-1] ? $unsigned(-force_val) : $unsigned(force_val);
    sv1 <= velocity[W-1];
    sg1 <= force_val[W-1];
    m1  <= mass;
  end

  always_ff @(posedge clk) begin
    p1_2 <= PROD_W'(av1) * PROD_W'(m1);
    p2_2 <= RG_W'(force_reduction) * RG_W'(ag1);
    p3_2 <= GT_W'(ag1) * GT_W'(time_step);
    pf_2 <= GT_W'(av1) * GT_W'(time_step);
    m2   <= m1;
    sv2  <= sv1;
    sg2  <= sg1;
  end

  always_ff @(posedge clk) begin
    q1l  <= (W+TIME_W)'(p1_2[W-1:0]) * (W+TIME_W)'(time_step);
    q1h  <= (W+TIME_W)'(p1_2[PROD_W-1:W]) * (W+TIME_W)'(time_step);
    q2l  <= (W+TIME_W)'(p2_2[W-1:0]) * (W+TIME_W)'(time_step);
    q2h  <= (RED_W+TIME_W)'(p2_2[RG_W-1:W]) * (RED_W+TIME_W)'(time_step);
    q3l  <= (W+TIME_W)'(p3_2[W-1:0]) * (W+TIME_W)'(time_step);
    q3h  <= (2*TIME_W)'(p3_2[GT_W-1:W]) * (2*TIME_W)'(time_step);
    p1_3 <= p1_2;
    fr3  <= FR_W'(pf_2 >> F) + FR_W'(pf_2[F-1]);
    m3   <= m2;
    sv3  <= sv2;
    sg3  <= sg2;
  end

  always_comb begin
    flim = sv3 ? (FR_W'(1) << (W-1)) : ((FR_W'(1) << (W-1)) - FR_W'(1));
    fmag = (fr3 > flim) ? flim : fr3;
  end

  always_ff @(posedge clk) begin
    vmt4 <= VMT_W'(q1l) + (VMT_W'(q1h) << W);
    rgt4 <= RGT_W'(q2l) + (RGT_W'(q2h) << W);
    gtt4 <= GTT_W'(q3l) + (GTT_W'(q3h) << W);
    p1_4 <= p1_3;
    f4   <= sv3 ? (~fmag[W-1:0] + 1'b1) : fmag[W-1:0];
    m4   <= m3;
    sv4  <= sv3;
    sg4  <= sg3;
  end

  always_comb begin
    ka = NUM_W'(p1_4) << (F + 1);
    kb = NUM_W'(rgt4);
    sa = NUM_W'(vmt4) << 1;
    sb = NUM_W'(gtt4);
  end

  always_ff @(posedge clk) begin
    kval5 <= (sv4 == sg4) ? (ka + kb) : (ka - kb);
    sval5 <= (sv4 == sg4) ? (sa + sb) : (sa - sb);
    ksub5 <= sv4 != sg4;
    ssub5 <= sv4 != sg4;
    sv5   <= sv4;
    m5    <= m4;
  end

  always_comb begin
    kflip = ksub5 && kval5[NUM_W-1];
    sflip = ssub5 && sval5[NUM_W-1];
    kmag  = kflip ? (~kval5 + 1'b1) : kval5;
    smag  = sflip ? (~sval5 + 1'b1) : sval5;
  end

  always_ff @(posedge clk) begin
    knh6   <= kmag[NUM_W-1:F+1];
    snh6   <= smag[NUM_W-1:F+1];
    khalf6 <= kmag[F];
    shalf6 <= smag[F];
    kneg6  <= sv5 ^ kflip;
    sneg6  <= sv5 ^ sflip;
    m6     <= m5;
  end

  vtu_div #(.W(W), .NH_W(NH_W)) u_kick_div (
    .clk     (clk),
    .num     (knh6),
    .half    (khalf6),
    .neg     (kneg6),
    .divisor (m6),
    .quot    (kick)
  );

  vtu_div #(.W(W), .NH_W(NH_W)) u_step_div (
    .clk     (clk),
    .num     (snh6),
    .half    (shalf6),
    .neg     (sneg6),
    .divisor (m6),
    .quot    (dstep)
  );

  always_ff @(posedge clk) begin
    vel_line[0]  <= velocity;
    disp_line[0] <= displacement;
    fs_line[0]   <= f4;
    for (int k = 1; k < LANE_LAT; k++) begin
      vel_line[k]  <= vel_line[k-1];
      disp_line[k] <= disp_line[k-1];
    end
    for (int k = 1; k < FS_LAT; k++) begin
      fs_line[k] <= fs_line[k-1];
    end
  end

  assign vel_out  = vel_line[LANE_LAT-1];
  assign disp_out = disp_line[LANE_LAT-1];
  assign fstep    = fs_line[FS_LAT-1];

endmodule

FILE: rtl/core/vtu_merge.sv
`include "assert_macros.svh"

module vtu_merge
  import vtu_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_t                     ctrl,
  input  logic [AXES-1:0][W-1:0]    kick,
  input  logic [AXES-1:0][W-1:0]    dstep,
  input  logic [AXES-1:0][W-1:0]    fstep,
  input  logic [AXES-1:0][W-1:0]    vel,
  input  logic [AXES-1:0][W-1:0]    disp,
  output logic                      done,
  output logic                      mass_error,
  output logic [AXES-1:0][W-1:0]    new_vel,
  output logic [AXES-1:0][W-1:0]    new_disp,
  output logic [AXES-1:0][W-1:0]    step
);

  localparam logic [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

  logic [AXES-1:0][W-1:0] nv_next, nx_next, st_next;

  always_comb begin
    logic       moving;
    logic [W:0] sum;
    moving = (ctrl.cmd == CMD_PREDICT) && !ctrl.mass_zero;
    for (int k = 0; k < AXES; k++) begin
      nv_next[k] = (!ctrl.fixed[k] && !ctrl.mass_zero) ? kick[k] : vel[k];
      st_next[k] = !moving ? '0 : (ctrl.fixed[k] ? fstep[k] : dstep[k]);
      sum        = {disp[k][W-1], disp[k]} + {st_next[k][W-1], st_next[k]};
      if (sum[W] != sum[W-1]) begin
        nx_next[k] = sum[W] ? SAT_MIN : SAT_MAX;
      end else begin
        nx_next[k] = sum[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    mass_error <= ctrl.mass_zero;
    new_vel    <= nv_next;
    new_disp   <= nx_next;
    step       <= st_next;
  end

  `CHECK_NEXT(a_no_step, clk, rst, ctrl.valid && (ctrl.cmd == CMD_CORRECT || ctrl.mass_zero), step == '0)
  `CHECK_NEXT(a_err_flag, clk, rst, ctrl.valid, done && (mass_error == $past(ctrl.mass_zero)))

endmodule

FILE: rtl/core/verlet_translation_update_top.sv
// Velocity Verlet translation update, three axes per particle.
// Input: raise start with command, fixed_mask, mass and the per-axis velocity,
// displacement and force; the transfer happens at a rising edge where start is
// high and busy is low. busy is high only during reset and the cycle after it,
// so an item may be offered every cycle: throughput is one item per clock.
// Output: done marks each result for exactly one cycle; the receiver must take
// it then, as the block never holds a result back. The pipelined dividers of
// each axis lane resolve one quotient bit per stage. Results leave in the
// order the items arrived.
// Configuration: write_enable, write_index and write_data set time_step
// (index 0) and force_reduction (index 1); write only while no item is in flight.
// Reset (rst, synchronous) restores time_step to 66 and force_reduction to
// 65536 and drops every item in flight.
`include "assert_macros.svh"

module verlet_translation_update_top
  import vtu_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          write_enable,
  input  logic [IDX_W-1:0]              write_index,
  input  logic [CFG_W-1:0]              write_data,
  input  logic                          command,
  input  logic [AXES-1:0]               fixed_mask,
  input  logic [VALUE_WIDTH-1:0]        mass,
  input  logic signed [VALUE_WIDTH-1:0] velocity_x,
  input  logic signed [VALUE_WIDTH-1:0] velocity_y,
  input  logic signed [VALUE_WIDTH-1:0] velocity_z,
  input  logic signed [VALUE_WIDTH-1:0] displacement_x,
  input  logic signed [VALUE_WIDTH-1:0] displacement_y,
  input  logic signed [VALUE_WIDTH-1:0] displacement_z,
  input  logic signed [VALUE_WIDTH-1:0] force_x,
  input  logic signed [VALUE_WIDTH-1:0] force_y,
  input  logic signed [VALUE_WIDTH-1:0] force_z,
  output logic                          done,
  output logic signed [VALUE_WIDTH-1:0] new_velocity_x,
  output logic signed [VALUE_WIDTH-1:0] new_velocity_y,
  output logic signed [VALUE_WIDTH-1:0] new_velocity_z,
  output logic signed [VALUE_WIDTH-1:0] new_displacement_x,
  output logic signed [VALUE_WIDTH-1:0] new_displacement_y,
  output logic signed [VALUE_WIDTH-1:0] new_displacement_z,
  output logic signed [VALUE_WIDTH-1:0] step_x,
  output logic signed [VALUE_WIDTH-1:0] step_y,
  output logic signed [VALUE_WIDTH-1:0] step_z,
  output logic                          mass_error
);

  localparam int W        = VALUE_WIDTH;
  localparam int LANE_LAT = W + LANE_FRONT + DIV_EXTRA;
  localparam int OUT_LAT  = LANE_LAT + 2;

  logic [TIME_W-1:0] time_step;
  logic [RED_W-1:0]  force_reduction;

  logic [W-1:0]           mass_q;
  logic [AXES-1:0][W-1:0] vel_q, disp_q, force_q;
  ctrl_t                  ctrl_q [0:LANE_LAT];

  logic [AXES-1:0][W-1:0] kick, dstep, fstep, vel_l, disp_l;
  logic [AXES-1:0][W-1:0] new_vel, new_disp, step;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step       <= TIME_RESET;
      force_reduction <= RED_RESET;
    end else if (write_enable) begin
      unique case (reg_idx_t'(write_index))
        REG_TIME_STEP: time_step       <= write_data[TIME_W-1:0];
        REG_FORCE_RED: force_reduction <= write_data[RED_W-1:0];
      endcase
    end
  end

  // capture every cycle; payload needs no reset
  always_ff @(posedge clk) begin
    mass_q     <= mass;
    vel_q[0]   <= velocity_x;
    vel_q[1]   <= velocity_y;
    vel_q[2]   <= velocity_z;
    disp_q[0]  <= displacement_x;
    disp_q[1]  <= displacement_y;
    disp_q[2]  <= displacement_z;
    force_q[0] <= force_x;
    force_q[1] <= force_y;
    force_q[2] <= force_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= LANE_LAT; k++) begin
        ctrl_q[k] <= '0;
      end
    end else begin
      ctrl_q[0].valid     <= start && !busy;
      ctrl_q[0].cmd       <= cmd_t'(command);
      ctrl_q[0].fixed     <= fixed_mask;
      ctrl_q[0].mass_zero <= mass == '0;
      for (int k = 1; k <= LANE_LAT; k++) begin
        ctrl_q[k] <= ctrl_q[k-1];
      end
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    vtu_lane #(.W(W), .F(FRAC_BITS)) u_lane (
      .clk             (clk),
      .mass            (mass_q),
      .time_step       (time_step),
      .force_reduction (force_reduction),
      .velocity        (vel_q[a]),
      .displacement    (disp_q[a]),
      .force_val       (force_q[a]),
      .kick            (kick[a]),
      .dstep           (dstep[a]),
      .fstep           (fstep[a]),
      .vel_out         (vel_l[a]),
      .disp_out        (disp_l[a])
    );
  end

  vtu_merge #(.W(W)) u_merge (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl_q[LANE_LAT]),
    .kick       (kick),
    .dstep      (dstep),
    .fstep      (fstep),
    .vel        (vel_l),
    .disp       (disp_l),
    .done       (done),
    .mass_error (mass_error),
    .new_vel    (new_vel),
    .new_disp   (new_disp),
    .step       (step)
  );

  assign new_velocity_x     = new_vel[0];
  assign new_velocity_y     = new_vel[1];
  assign new_velocity_z     = new_vel[2];
  assign new_displacement_x = new_disp[0];
  assign new_displacement_y = new_disp[1];
  assign new_displacement_z = new_disp[2];
  assign step_x             = step[0];
  assign step_y             = step[1];
  assign step_z             = step[2];

  `CHECK_DELAY(a_latency, clk, rst, start && !busy, OUT_LAT, done)
  `CHECK_IMPL(a_origin, clk, rst, done, $past(start && !busy, OUT_LAT))

endmodule

FILE: tb/sv/tb_verlet_translation_update_top.sv
`timescale 1ns / 1ps

module tb_verlet_translation_update_top;
  import vtu_pkg::*;

  localparam int W = 32;
  localparam int LATENCY = W + 11;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic            cmd;
    logic [2:0]      fm;
    logic [W-1:0]    m;
    logic [2:0][W-1:0] v;
    logic [2:0][W-1:0] x;
    logic [2:0][W-1:0] f;
  } particle_t;

  typedef struct packed {
    logic [2:0][W-1:0] nv;
    logic [2:0][W-1:0] nx;
    logic [2:0][W-1:0] st;
    logic              err;
  } update_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic write_enable = 1'b0;
  logic [IDX_W-1:0] write_index = '0;
  logic [CFG_W-1:0] write_data = '0;
  particle_t cur = '0;
  logic done, mass_error;
  logic signed [W-1:0] nvx, nvy, nvz, nxx, nxy, nxz, stx, sty, stz;

  particle_t pending_q[$];
  update_t   expected_q[$];
  logic [TIME_W-1:0] ts_model = TIME_RESET;
  logic [RED_W-1:0]  red_model = RED_RESET;
  int sender_idle_pct = 0;
  int mismatches = 0;
  int accepted = 0;
  int checked = 0;
  int settings_used = 1;
  int quiet_cycles = 0;
  bit took = 0;

  always #6 clk = ~clk;

  verlet_translation_update_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data),
    .command(cur.cmd), .fixed_mask(cur.fm), .mass(cur.m),
    .velocity_x(cur.v[0]), .velocity_y(cur.v[1]), .velocity_z(cur.v[2]),
    .displacement_x(cur.x[0]), .displacement_y(cur.x[1]), .displacement_z(cur.x[2]),
    .force_x(cur.f[0]), .force_y(cur.f[1]), .force_z(cur.f[2]),
    .done(done),
    .new_velocity_x(nvx), .new_velocity_y(nvy), .new_velocity_z(nvz),
    .new_displacement_x(nxx), .new_displacement_y(nxy), .new_displacement_z(nxz),
    .step_x(stx), .step_y(sty), .step_z(stz), .mass_error(mass_error)
  );

  function automatic logic [W-1:0] clamp32(logic signed [159:0] a);
    if (a > 160'sd2147483647) return 32'h7fff_ffff;
    if (a < -160'sd2147483648) return 32'h8000_0000;
    return a[W-1:0];
  endfunction

  function automatic logic [W-1:0] round_quot(logic signed [159:0] n, logic [159:0] d);
    logic [159:0] mag, q, r;
    logic signed [159:0] val;
    mag = n < 0 ? $unsigned(-n) : $unsigned(n);
    q = mag / d;
    r = mag % d;
    if ((r << 1) >= d) q = q + 1;
    val = n < 0 ? -$signed(q) : $signed(q);
    return clamp32(val);
  endfunction

  function automatic update_t verlet_update(particle_t p);
    update_t u;
    logic signed [159:0] vv, xx, gg, mm, tt, rr, n;
    logic [159:0] den;
    logic [W-1:0] st;
    mm = {128'd0, p.m};
    tt = {129'd0, ts_model};
    rr = {142'd0, red_model};
    den = $unsigned(mm) << (16 + 1);
    for (int k = 0; k < 3; k++) begin
      vv = {{128{p.v[k][W-1]}}, p.v[k]};
      xx = {{128{p.x[k][W-1]}}, p.x[k]};
      gg = {{128{p.f[k][W-1]}}, p.f[k]};
      st = '0;
      u.nv[k] = p.v[k];
      u.nx[k] = p.x[k];
      if (p.m != 0 && !p.fm[k]) begin
        n = vv * mm * 160'sd131072 + rr * gg * tt;
        u.nv[k] = round_quot(n, den);
        if (p.cmd == CMD_PREDICT) begin
          n = vv * mm * tt * 160'sd2 + gg * tt * tt;
          st = round_quot(n, den);
        end
      end else if (p.m != 0 && p.cmd == CMD_PREDICT) begin
        st = round_quot(vv * tt, 160'd65536);
      end
      if (p.m != 0 && p.cmd == CMD_PREDICT)
        u.nx[k] = clamp32(xx + {{128{st[W-1]}}, st});
      u.st[k] = st;
    end
    u.err = (p.m == 0);
    return u;
  endfunction

  function automatic logic [W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      3, 4: return $urandom();
      default: return $urandom_range(0, 32'h0003_ffff) - 32'h0002_0000;
    endcase
  endfunction

  function automatic particle_t random_particle();
    particle_t p;
    p.cmd = $urandom_range(0, 1) ? CMD_CORRECT : CMD_PREDICT;
    p.fm = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0: p.m = '0;
      1: p.m = 32'hffff_ffff;
      2, 3: p.m = $urandom();
      default: p.m = $urandom_range(1, 32'h0010_0000);
    endcase
    for (int k = 0; k < 3; k++) begin
      p.v[k] = pick_value();
      p.x[k] = pick_value();
      p.f[k] = pick_value();
    end
    return p;
  endfunction

  task automatic add_directed(logic c, logic [2:0] fm, logic [W-1:0] m, logic [W-1:0] v,
                              logic [W-1:0] x, logic [W-1:0] f);
    particle_t p;
    p.cmd = c;
    p.fm = fm;
    p.m = m;
    p.v = {v, ~v, v};
    p.x = {x, x, ~x};
    p.f = {f, ~f, f};
    pending_q.push_back(p);
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && expected_q.size() == 0);
    repeat (LATENCY + 8) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= data;
    if (idx == REG_TIME_STEP) ts_model = data[TIME_W-1:0];
    else red_model = data[RED_W-1:0];
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  always @(posedge clk) begin
    took = !rst && start && !busy;
    if (took) begin
      expected_q.push_back(verlet_update(cur));
      accepted++;
    end
    if (!rst && done) begin
      update_t got, want;
      got.nv = {nvz, nvy, nvx};
      got.nx = {nxz, nxy, nxx};
      got.st = {stz, sty, stx};
      got.err = mass_error;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer at %0t", $realtime);
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected v=%h x=%h s=%h e=%b", checked,
                     want.nv, want.nx, want.st, want.err);
            $display("result %0d:   actual v=%h x=%h s=%h e=%b", checked,
                     got.nv, got.nx, got.st, got.err);
          end
        end
      end
    end
    quiet_cycles = (took || done || rst) ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (took && pending_q.size() > 0) void'(pending_q.pop_front());
    if (!rst && pending_q.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
      cur <= pending_q[0];
      start <= 1'b1;
    end else begin
      start <= 1'b0;
    end
  end

  initial begin
    logic [TIME_W-1:0] ts_set[6];
    logic [RED_W-1:0]  red_set[6];
    ts_set  = '{31'd66, 31'd0, 31'h7fff_ffff, 31'd65536, 31'd1, 31'd6554};
    red_set = '{18'd65536, 18'd0, 18'd131072, 18'h3ffff, 18'd1, 18'd32768};
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    sender_idle_pct = 33;

    add_directed(CMD_PREDICT, 3'b000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0002_0000);
    add_directed(CMD_CORRECT, 3'b000, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0002_0000);
    add_directed(CMD_PREDICT, 3'b111, 32'h0001_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h0);
    add_directed(CMD_CORRECT, 3'b111, 32'h0001_0000, 32'h8000_0000, 32'h8000_0000, 32'h1);
    add_directed(CMD_PREDICT, 3'b000, 32'h0, 32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff);
    add_directed(CMD_CORRECT, 3'b101, 32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    add_directed(CMD_PREDICT, 3'b010, 32'h0000_0001, 32'h7fff_ffff, 32'h7fff_0000, 32'h7fff_ffff);
    add_directed(CMD_PREDICT, 3'b000, 32'h0000_0001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_directed(CMD_CORRECT, 3'b100, 32'hffff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff);
    add_directed(CMD_PREDICT, 3'b001, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'h1);
    add_directed(CMD_PREDICT, 3'b110, 32'h0000_8000, 32'hffff_8000, 32'h0000_0001, 32'hffff_ffff);
    add_directed(CMD_CORRECT, 3'b011, 32'h0003_0000, 32'h0000_0000, 32'h5555_5555, 32'haaaa_aaaa);
    drain();

    for (int s = 1; s < 6; s++) begin
      write_reg(REG_TIME_STEP, CFG_W'(ts_set[s]));
      write_reg(REG_FORCE_RED, CFG_W'(red_set[s]));
      settings_used++;
      repeat (40) pending_q.push_back(random_particle());
      drain();
    end

    for (int s = 0; s < 6; s++) begin
      sender_idle_pct = s < 2 ? 54 : 0;
      write_reg(REG_TIME_STEP, s == 0 ? CFG_W'(66) : CFG_W'($urandom_range(0, 32'h0004_0000)));
      write_reg(REG_FORCE_RED, CFG_W'($urandom_range(0, 18'h3ffff)));
      settings_used++;
      repeat (35) pending_q.push_back(random_particle());
      drain();
    end

    $display("Covered %0d particle updates, %0d results checked, over %0d register settings",
             accepted, checked, settings_used);
    $display("with sender gaps at 33 and 54 percent and back-to-back transfers.");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
